/* design/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define DLCG_ASSERT_IMP(name, clk, rst, a, c) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("dlcg assertion failed");

// Next-cycle implication, off while reset is high.
`define DLCG_ASSERT_NXT(name, clk, rst, a, c) \
  name: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("dlcg assertion failed");

// Next-cycle implication that is checked during reset as well.
`define DLCG_ASSERT_NXT_ALL(name, clk, a, c) \
  name: assert property (@(posedge clk) (a) |=> (c)) \
    else $error("dlcg assertion failed");

`endif

/* design/dlcg_pkg.sv */
package dlcg_pkg;

  // Field widths
  localparam int SEED_W  = 27;
  localparam int VALUE_W = 28;
  localparam int RANGE_W = 16;
  localparam int SPAN_W  = 16;   // magnitude of range_high - range_low
  localparam int DIGIT_W = 14;   // four decimal digits, 0..9999
  localparam int CMD_W   = 2;

  // Recurrence constants
  localparam int LCG_MOD  = 100000000;
  localparam int LCG_HALF = 10000;
  localparam int LCG_MUL  = 31415821;
  localparam int MUL_HI   = LCG_MUL / LCG_HALF;   // upper four digits
  localparam int MUL_LO   = LCG_MUL % LCG_HALF;   // lower four digits

  // Divide-by-10000 unit: reciprocal multiply plus one correction step
  localparam int DIV_X_W     = 30;
  localparam int DIV_Q_W     = 17;
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP       = (2 ** RECIP_SHIFT) / LCG_HALF;
  localparam int RECIP_W     = 17;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_RAW   = 2'd1,
    CMD_RANGE = 2'd2,
    CMD_COIN  = 2'd3
  } cmd_t;

  // Work classes handed from the front end to the back end
  typedef enum logic [2:0] {
    OP_LOAD,
    OP_RAW,
    OP_RANGE,
    OP_COIN,
    OP_FIXED
  } op_kind_t;

  typedef struct packed {
    op_kind_t             kind;
    logic [SEED_W-1:0]    seed_value;
    logic [RANGE_W-1:0]   range_low;
    logic [SPAN_W-1:0]    span_mag;
    logic                 span_neg;
    logic [DIGIT_W-1:0]   threshold;
    logic                 coin;
    logic                 error;
  } op_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_X_W-1:0]   x;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_Q_W-1:0]   q;
    logic [DIGIT_W-1:0]   r;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SPLIT,
    ST_MIX,
    ST_FOLD,
    ST_WRAP,
    ST_FRAC,
    ST_SCALE,
    ST_QUOT,
    ST_EMIT
  } state_t;

endpackage

/* design/dlcg_req_if.sv */
interface dlcg_req_if;
  logic                          valid;
  logic                          ready;
  logic [dlcg_pkg::CMD_W-1:0]    command;
  logic [dlcg_pkg::SEED_W-1:0]   seed_value;
  logic signed [dlcg_pkg::RANGE_W-1:0] range_low;
  logic signed [dlcg_pkg::RANGE_W-1:0] range_high;
  logic [dlcg_pkg::DIGIT_W-1:0]  coin_threshold;

  modport source (
    output valid, command, seed_value, range_low, range_high, coin_threshold,
    input  ready
  );

  modport sink (
    input  valid, command, seed_value, range_low, range_high, coin_threshold,
    output ready
  );
endinterface

/* design/dlcg_rsp_if.sv */
interface dlcg_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [dlcg_pkg::VALUE_W-1:0] value;
  logic                                coin;
  logic                                error;

  modport source (
    output valid, value, coin, error,
    input  ready
  );

  modport sink (
    input  valid, value, coin, error,
    output ready
  );
endinterface

/* design/dlcg_div10k.sv */
// Quotient and remainder of x / 10000 for x below 2**30.
// Registered steps from start to done: input register, reciprocal multiply,
// back-multiply, remainder with a single correction.
module dlcg_div10k (
  input  logic               clk,
  input  logic               rst,
  input  dlcg_pkg::div_req_t cmd,
  output dlcg_pkg::div_rsp_t res
);
  import dlcg_pkg::*;

  localparam int PROD_W = DIV_X_W + RECIP_W;
  localparam int QM_W   = DIV_X_W + 1;

  logic [2:0]          stage_valid;
  logic [DIV_X_W-1:0]  x_in;
  logic [DIV_X_W-1:0]  x_d1;
  logic [DIV_X_W-1:0]  x_d2;
  logic [PROD_W-1:0]   prod;
  logic [DIV_Q_W-1:0]  q_est;
  logic [DIV_Q_W-1:0]  q_d2;
  logic [QM_W-1:0]     q_back;
  logic [QM_W-1:0]     rem_raw;
  logic                rem_fix;
  logic                done;
  logic [DIV_Q_W-1:0]  quo;
  logic [DIGIT_W-1:0]  rem;

  // reciprocal estimate is at most one short
  assign q_est   = prod[RECIP_SHIFT +: DIV_Q_W];
  assign rem_raw = {1'b0, x_d2} - q_back;
  assign rem_fix = rem_raw >= QM_W'(LCG_HALF);

  // valid pipe
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
      done        <= 1'b0;
    end else begin
      stage_valid <= {stage_valid[1:0], cmd.start};
      done        <= stage_valid[2];
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      x_in <= cmd.x;
    end
    prod   <= PROD_W'(x_in) * PROD_W'(RECIP);
    x_d1   <= x_in;
    q_d2   <= q_est;
    q_back <= QM_W'(q_est) * QM_W'(LCG_HALF);
    x_d2   <= x_d1;
    if (rem_fix) begin
      quo <= q_d2 + 1'b1;
      rem <= DIGIT_W'(rem_raw - QM_W'(LCG_HALF));
    end else begin
      quo <= q_d2;
      rem <= DIGIT_W'(rem_raw);
    end
  end

  assign res.done = done;
  assign res.q    = quo;
  assign res.r    = rem;

endmodule

/* design/dlcg_queue.sv */
// Small command queue between the front end and the back end.
// DEPTH must be 2 or more.
module dlcg_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  dlcg_pkg::op_t push_op,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output dlcg_pkg::op_t pop_op
);
  import dlcg_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t              entry [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full   = count == CNT_W'(DEPTH);
  assign valid  = count != '0;
  assign pop_op = entry[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_op;
    end
  end

endmodule

/* design/dlcg_front.sv */
// Front end: takes a transaction, sorts it into a work class, precomputes
// the range span and settles the coin outcomes that need no advance.
module dlcg_front (
  dlcg_req_if.sink      req,
  input  logic          q_full,
  output logic          push,
  output dlcg_pkg::op_t push_op
);
  import dlcg_pkg::*;

  logic signed [SPAN_W:0] span;
  logic signed [SPAN_W:0] span_abs;

  assign req.ready = !q_full;
  assign push      = req.valid && !q_full;

  // span of the range, kept as sign and magnitude
  always_comb begin
    span     = (SPAN_W + 1)'(req.range_high) - (SPAN_W + 1)'(req.range_low);
    span_abs = span[SPAN_W] ? -span : span;
  end

  // classification
  always_comb begin
    push_op.kind       = OP_FIXED;
    push_op.seed_value = req.seed_value;
    push_op.range_low  = req.range_low;
    push_op.span_mag   = span_abs[SPAN_W-1:0];
    push_op.span_neg   = span[SPAN_W];
    push_op.threshold  = req.coin_threshold;
    push_op.coin       = 1'b0;
    push_op.error      = 1'b0;
    case (cmd_t'(req.command))
      CMD_LOAD:  push_op.kind = OP_LOAD;
      CMD_RAW:   push_op.kind = OP_RAW;
      CMD_RANGE: push_op.kind = OP_RANGE;
      CMD_COIN: begin
        // out of range, certain, and impossible coins leave the seed alone
        if (req.coin_threshold > DIGIT_W'(LCG_HALF)) begin
          push_op.error = 1'b1;
        end else if (req.coin_threshold == DIGIT_W'(LCG_HALF)) begin
          push_op.coin = 1'b1;
        end else if (req.coin_threshold != '0) begin
          push_op.kind = OP_COIN;
        end
      end
      default:   push_op.kind = OP_FIXED;
    endcase
  end

endmodule

/* design/dlcg_back.sv */
// Back end: advances the seed in split decimal form and forms the result.
// s = sh*1e4 + sl, M = MUL_HI*1e4 + MUL_LO:
// (s*M + 1) mod 1e8 = ((sh*MUL_LO + sl*MUL_HI) mod 1e4)*1e4 + sl*MUL_LO + 1,
// with one final subtract of 1e8.
module dlcg_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  dlcg_pkg::op_t      q_op,
  output logic               pop,
  output dlcg_pkg::div_req_t div_cmd,
  input  dlcg_pkg::div_rsp_t div_res,
  dlcg_rsp_if.source         rsp
);
  import dlcg_pkg::*;

  localparam int MIXA_W = 26;
  localparam int SUM_W  = 28;

  state_t              state;
  state_t              state_next;
  op_t                 op;
  logic [SEED_W-1:0]   seed;
  logic [DIGIT_W-1:0]  sh;
  logic [DIGIT_W-1:0]  sl;
  logic [MIXA_W-1:0]   mix_a;
  logic [SUM_W-1:0]    sum;
  logic [DIGIT_W-1:0]  frac;
  logic [VALUE_W-1:0]  res_value;
  logic                res_coin;
  logic                res_error;
  logic                out_valid;
  logic [VALUE_W-1:0]  out_value;
  logic                out_coin;
  logic                out_error;

  logic                out_free;
  logic                needs_adv;
  logic [SEED_W-1:0]   seed_red;
  logic [SEED_W-1:0]   mix_b;
  logic [MIXA_W-1:0]   mix_a_next;
  logic [SUM_W-1:0]    sum_next;
  logic [SEED_W-1:0]   seed_new;
  logic [DIV_X_W-1:0]  frac_prod;
  logic [VALUE_W-1:0]  lo_ext;
  logic [VALUE_W-1:0]  q_ext;
  logic [VALUE_W-1:0]  range_value;

  assign out_free  = !out_valid || rsp.ready;
  assign needs_adv = !(q_op.kind == OP_LOAD || q_op.kind == OP_FIXED);

  // arithmetic between the sequencer steps
  always_comb begin
    seed_red    = (seed >= SEED_W'(LCG_MOD)) ? seed - SEED_W'(LCG_MOD) : seed;
    mix_b       = SEED_W'(sh) * SEED_W'(MUL_LO) + SEED_W'(sl) * SEED_W'(MUL_HI);
    mix_a_next  = MIXA_W'(sl) * MIXA_W'(MUL_LO);
    sum_next    = SUM_W'(mix_a) + SUM_W'(div_res.r) * SUM_W'(LCG_HALF) + SUM_W'(1);
    seed_new    = (sum >= SUM_W'(LCG_MOD)) ? SEED_W'(sum - SUM_W'(LCG_MOD))
                                           : SEED_W'(sum);
    frac_prod   = DIV_X_W'(frac) * DIV_X_W'(op.span_mag);
    lo_ext      = {{(VALUE_W - RANGE_W){op.range_low[RANGE_W-1]}}, op.range_low};
    q_ext       = VALUE_W'(div_res.q);
    range_value = op.span_neg ? lo_ext - q_ext : lo_ext + q_ext;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          state_next = needs_adv ? ST_SPLIT : ST_EMIT;
        end
      end
      ST_SPLIT: if (div_res.done) state_next = ST_MIX;
      ST_MIX:   state_next = ST_FOLD;
      ST_FOLD:  if (div_res.done) state_next = ST_WRAP;
      ST_WRAP:  state_next = (op.kind == OP_RAW) ? ST_EMIT : ST_FRAC;
      ST_FRAC: begin
        if (div_res.done) begin
          state_next = (op.kind == OP_RANGE) ? ST_SCALE : ST_EMIT;
        end
      end
      ST_SCALE: state_next = ST_QUOT;
      ST_QUOT:  if (div_res.done) state_next = ST_EMIT;
      ST_EMIT:  if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs: queue pop and divider requests
  always_comb begin
    pop           = 1'b0;
    div_cmd.start = 1'b0;
    div_cmd.x     = '0;
    case (state)
      ST_IDLE: begin
        pop           = q_valid;
        div_cmd.start = q_valid && needs_adv;
        div_cmd.x     = DIV_X_W'(seed_red);
      end
      ST_MIX: begin
        div_cmd.start = 1'b1;
        div_cmd.x     = DIV_X_W'(mix_b);
      end
      ST_WRAP: begin
        div_cmd.start = op.kind != OP_RAW;
        div_cmd.x     = DIV_X_W'(seed_new);
      end
      ST_SCALE: begin
        div_cmd.start = 1'b1;
        div_cmd.x     = frac_prod;
      end
      default: begin
        pop           = 1'b0;
        div_cmd.start = 1'b0;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      seed      <= SEED_W'(1);
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && q_valid && q_op.kind == OP_LOAD) begin
        seed <= q_op.seed_value;
      end else if (state == ST_WRAP) begin
        seed <= seed_new;
      end
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          op        <= q_op;
          res_value <= '0;
          res_coin  <= q_op.coin;
          res_error <= q_op.error;
        end
      end
      ST_SPLIT: begin
        if (div_res.done) begin
          sh <= div_res.q[DIGIT_W-1:0];
          sl <= div_res.r;
        end
      end
      ST_MIX:  mix_a <= mix_a_next;
      ST_FOLD: if (div_res.done) sum <= sum_next;
      ST_WRAP: begin
        if (op.kind == OP_RAW) begin
          res_value <= VALUE_W'(seed_new);
        end
      end
      ST_FRAC: begin
        if (div_res.done) begin
          frac <= div_res.q[DIGIT_W-1:0];
          if (op.kind == OP_COIN) begin
            res_coin <= op.threshold > div_res.q[DIGIT_W-1:0];
          end
        end
      end
      ST_QUOT: if (div_res.done) res_value <= range_value;
      ST_EMIT: begin
        if (out_free) begin
          out_value <= res_value;
          out_coin  <= res_coin;
          out_error <= res_error;
        end
      end
      default: begin
        frac <= frac;
      end
    endcase
  end

  assign rsp.valid = out_valid;
  assign rsp.value = out_value;
  assign rsp.coin  = out_coin;
  assign rsp.error = out_error;

endmodule

/* design/decimal_lcg_random_generator_unit.sv */
// Back end steps per transaction: a loaded seed or a coin with a settled
// outcome goes straight to emit; raw next passes split, mix, fold and wrap;
// an advancing coin adds frac, a scaled range frac, scale and quot.
// The shared divide-by-10000 unit is used two to four times.
// rst (synchronous) empties the queue and output register and sets seed to 1.
module decimal_lcg_random_generator_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst,
  dlcg_req_if.sink   req,
  dlcg_rsp_if.source rsp
);
  import dlcg_pkg::*;

  logic     q_full;
  logic     push;
  logic     pop;
  logic     q_valid;
  op_t      push_op;
  op_t      q_op;
  div_req_t div_cmd;
  div_rsp_t div_res;

  dlcg_front u_front (
    .req     (req),
    .q_full  (q_full),
    .push    (push),
    .push_op (push_op)
  );

  dlcg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .full    (q_full),
    .pop     (pop),
    .valid   (q_valid),
    .pop_op  (q_op)
  );

  dlcg_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_op    (q_op),
    .pop     (pop),
    .div_cmd (div_cmd),
    .div_res (div_res),
    .rsp     (rsp)
  );

  dlcg_div10k u_div (
    .clk (clk),
    .rst (rst),
    .cmd (div_cmd),
    .res (div_res)
  );

endmodule

/* design/dlcg_checker.sv */
`include "assert_macros.svh"

// Port-level checks on the generator.
module dlcg_port_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [dlcg_pkg::VALUE_W-1:0] rsp_value,
  input logic                         rsp_coin,
  input logic                         rsp_error
);
  import dlcg_pkg::*;

  logic [7:0]         pending;
  logic               in_acc;
  logic               out_acc;
  logic [VALUE_W+1:0] rsp_word;

  assign in_acc   = req_valid && req_ready;
  assign out_acc  = rsp_valid && rsp_ready;
  assign rsp_word = {rsp_value, rsp_coin, rsp_error};

  // transactions accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {7'd0, in_acc} - {7'd0, out_acc};
    end
  end

  `DLCG_ASSERT_NXT_ALL(a_reset_empty, clk, rst, !rsp_valid)
  `DLCG_ASSERT_NXT(a_stall_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))
  `DLCG_ASSERT_IMP(a_no_extra, clk, rst, rsp_valid, pending != 8'd0)
  `DLCG_ASSERT_IMP(a_error_clean, clk, rst, rsp_valid && rsp_error, !rsp_coin && rsp_value == '0)
  `DLCG_ASSERT_IMP(a_coin_clean, clk, rst, rsp_valid && rsp_coin, rsp_value == '0)

endmodule

bind decimal_lcg_random_generator_unit dlcg_port_checker u_dlcg_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_value (rsp.value),
  .rsp_coin  (rsp.coin),
  .rsp_error (rsp.error)
);
